// ----- src/gne_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the grid neighbor expander.
// Used by gne_datapath, gne_ctrl and grid_neighbor_expander.
package gne_pkg;

	localparam int NODE_W = 12;
	localparam int COST_W = 16;
	localparam int SLOT_W = 3;

	localparam logic [COST_W-1:0] STRAIGHT_RST = 16'd10;
	localparam logic [COST_W-1:0] DIAGONAL_RST = 16'd14;

	// configuration register indexes
	localparam logic CFG_STRAIGHT = 1'b0;
	localparam logic CFG_DIAGONAL = 1'b1;

	// item mode codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_Q_UP,
		ST_Q_MID,
		ST_Q_DN,
		ST_Q_CAP,
		ST_EMIT,
		ST_W_RD,
		ST_W_WB
	} gne_state_t;

	typedef enum logic [1:0] {
		ROW_UP,
		ROW_MID,
		ROW_DN
	} row_sel_t;

	typedef struct packed {
		logic              load;
		logic              do_div;
		logic              do_fix;
		logic              rd_en;
		row_sel_t          rd_sel;
		logic              cap_en;
		row_sel_t          cap_sel;
		logic              wr_en;
		logic              emit_en;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} gne_cmd_t;

	typedef struct packed {
		logic is_query;
	} gne_stat_t;

	// 3x3 window position of a neighbor slot; the center is skipped
	typedef struct packed {
		logic [1:0] ri;
		logic [1:0] ci;
	} win_pos_t;

	function automatic win_pos_t slot_pos(input logic [SLOT_W-1:0] slot);
		win_pos_t p;
		unique case (slot)
			3'd0: p = '{ri: 2'd0, ci: 2'd0};
			3'd1: p = '{ri: 2'd0, ci: 2'd1};
			3'd2: p = '{ri: 2'd0, ci: 2'd2};
			3'd3: p = '{ri: 2'd1, ci: 2'd0};
			3'd4: p = '{ri: 2'd1, ci: 2'd2};
			3'd5: p = '{ri: 2'd2, ci: 2'd0};
			3'd6: p = '{ri: 2'd2, ci: 2'd1};
			3'd7: p = '{ri: 2'd2, ci: 2'd2};
			default: p = '{ri: 2'd1, ci: 2'd1};
		endcase
		return p;
	endfunction

endpackage

// ----- src/gne_map.sv -----
`timescale 1ns / 1ps
// Blocked map: one row of the grid per memory word, registered read.
// Per-row valid bits make rows that were never written read as free.
module gne_map #(
	parameter int GRID_SIDE = 64,
	parameter int AW        = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [GRID_SIDE-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [GRID_SIDE-1:0] wr_data
);

	logic [GRID_SIDE-1:0] mem [GRID_SIDE];
	logic [GRID_SIDE-1:0] vld_q;
	logic [GRID_SIDE-1:0] mem_rd_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

// ----- src/gne_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: item and cost registers, row/column split, 3x3 window and result registers.
// Depends on gne_pkg and gne_map.
module gne_datapath #(
	parameter int GRID_SIDE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gne_pkg::gne_cmd_t            cmd,
	output gne_pkg::gne_stat_t           stat,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [gne_pkg::COST_W-1:0]   cfg_data,
	input  logic                         mode,
	input  logic [gne_pkg::NODE_W-1:0]   node,
	input  logic                         blocked,
	output logic                         result_strobe,
	output logic [gne_pkg::SLOT_W-1:0]   direction,
	output logic [gne_pkg::NODE_W-1:0]   neighbor_node,
	output logic [gne_pkg::COST_W-1:0]   step_cost,
	output logic                         reachable,
	output logic                         last_of_run
);

	localparam int NW    = gne_pkg::NODE_W;
	localparam int CW    = gne_pkg::COST_W;
	localparam int AW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int SHIFT = 19;
	localparam int PW    = NW + SHIFT;
	// reciprocal of the side; exact for every 12-bit node up to a side of 64
	localparam logic [SHIFT-1:0] RECIP   = SHIFT'(((1 << SHIFT) + GRID_SIDE - 1) / GRID_SIDE);
	localparam logic [NW:0]      CELLS   = (NW + 1)'(GRID_SIDE * GRID_SIDE);
	localparam logic [NW-1:0]    SIDE_N  = NW'(GRID_SIDE);
	localparam logic [AW-1:0]    LAST_RC = AW'(GRID_SIDE - 1);

	logic [CW-1:0]        straight_q;
	logic [CW-1:0]        diagonal_q;
	logic                 mode_q;
	logic [NW-1:0]        node_q;
	logic                 blocked_q;
	logic                 node_ok_q;
	logic [PW-1:0]        prod_q;
	logic [AW-1:0]        row_q;
	logic [AW-1:0]        col_q;
	logic [2:0][2:0]      win_q;

	logic [NW-1:0]        quot;
	logic [NW-1:0]        col_full;
	logic [AW-1:0]        row_up;
	logic [AW-1:0]        row_dn;
	logic [AW-1:0]        col_l;
	logic [AW-1:0]        col_r;
	logic [AW-1:0]        rd_addr;
	logic [GRID_SIDE-1:0] rd_data;
	logic [GRID_SIDE-1:0] wr_data;
	logic [2:0]           cap_bits;

	gne_pkg::win_pos_t    pos;
	logic                 diag;
	logic                 row_in;
	logic                 col_in;
	logic                 in_grid;
	logic                 free;
	logic                 ok;
	logic [NW-1:0]        nbase;
	logic [NW-1:0]        nidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q <= gne_pkg::STRAIGHT_RST;
			diagonal_q <= gne_pkg::DIAGONAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gne_pkg::CFG_STRAIGHT: straight_q <= cfg_data;
				gne_pkg::CFG_DIAGONAL: diagonal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign quot     = prod_q[PW-1:SHIFT];
	assign col_full = node_q - NW'(quot * SIDE_N);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= mode;
			node_q    <= node;
			blocked_q <= blocked;
			node_ok_q <= ({1'b0, node} < CELLS);
		end
		if (cmd.do_div) begin
			prod_q <= PW'(node_q) * PW'(RECIP);
		end
		if (cmd.do_fix) begin
			// out-of-grid nodes read row zero; their results are masked anyway
			row_q <= node_ok_q ? quot[AW-1:0] : '0;
			col_q <= node_ok_q ? col_full[AW-1:0] : '0;
		end
	end

	assign stat.is_query = (mode_q == gne_pkg::MODE_QUERY);

	// clamp at the edges; cells beyond the border are masked by the range checks
	assign row_up = (row_q == '0) ? row_q : row_q - AW'(1);
	assign row_dn = (row_q == LAST_RC) ? row_q : row_q + AW'(1);
	assign col_l  = (col_q == '0) ? col_q : col_q - AW'(1);
	assign col_r  = (col_q == LAST_RC) ? col_q : col_q + AW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			gne_pkg::ROW_UP:  rd_addr = row_up;
			gne_pkg::ROW_MID: rd_addr = row_q;
			gne_pkg::ROW_DN:  rd_addr = row_dn;
			default:          rd_addr = row_q;
		endcase
	end

	always_comb begin
		wr_data        = rd_data;
		wr_data[col_q] = blocked_q;
	end

	gne_map #(
		.GRID_SIDE (GRID_SIDE),
		.AW        (AW)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (cmd.wr_en & node_ok_q),
		.wr_addr (row_q),
		.wr_data (wr_data)
	);

	assign cap_bits = {rd_data[col_r], rd_data[col_q], rd_data[col_l]};

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			unique case (cmd.cap_sel)
				gne_pkg::ROW_UP:  win_q[0] <= cap_bits;
				gne_pkg::ROW_MID: win_q[1] <= cap_bits;
				gne_pkg::ROW_DN:  win_q[2] <= cap_bits;
				default: ;
			endcase
		end
	end

	// neighbor evaluation for the current slot
	always_comb begin
		pos  = gne_pkg::slot_pos(cmd.slot);
		diag = (pos.ri != 2'd1) && (pos.ci != 2'd1);

		unique case (pos.ri)
			2'd0:    row_in = (row_q != '0);
			2'd1:    row_in = 1'b1;
			2'd2:    row_in = (row_q != LAST_RC);
			default: row_in = 1'b0;
		endcase
		unique case (pos.ci)
			2'd0:    col_in = (col_q != '0);
			2'd1:    col_in = 1'b1;
			2'd2:    col_in = (col_q != LAST_RC);
			default: col_in = 1'b0;
		endcase
		in_grid = node_ok_q && row_in && col_in;

		free = !win_q[pos.ri][pos.ci];
		if (diag) begin
			free = free && !win_q[1][pos.ci] && !win_q[pos.ri][1];
		end
		ok = in_grid && free;

		unique case (pos.ri)
			2'd0:    nbase = node_q - SIDE_N;
			2'd2:    nbase = node_q + SIDE_N;
			default: nbase = node_q;
		endcase
		unique case (pos.ci)
			2'd0:    nidx = nbase - NW'(1);
			2'd2:    nidx = nbase + NW'(1);
			default: nidx = nbase;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_en) begin
			direction     <= cmd.slot;
			neighbor_node <= in_grid ? nidx : '0;
			step_cost     <= ok ? (diag ? diagonal_q : straight_q) : '0;
			reachable     <= ok;
			last_of_run   <= cmd.last;
		end
	end

endmodule

// ----- src/gne_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences the row/column split, map reads and writes and the eight results.
// Depends on gne_pkg.
module gne_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gne_pkg::gne_stat_t stat,
	output gne_pkg::gne_cmd_t  cmd
);

	gne_pkg::gne_state_t            state_q;
	gne_pkg::gne_state_t            state_d;
	logic [gne_pkg::SLOT_W-1:0]     slot_q;
	logic [gne_pkg::SLOT_W-1:0]     slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gne_pkg::ST_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		cmd         = '0;
		cmd.rd_sel  = gne_pkg::ROW_MID;
		cmd.cap_sel = gne_pkg::ROW_MID;
		cmd.slot    = slot_q;
		cmd.last    = (slot_q == gne_pkg::SLOT_LAST);
		busy        = (state_q != gne_pkg::ST_IDLE);

		unique case (state_q)
			gne_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = gne_pkg::ST_DIV;
				end
			end
			gne_pkg::ST_DIV: begin
				cmd.do_div = 1'b1;
				state_d    = gne_pkg::ST_FIX;
			end
			gne_pkg::ST_FIX: begin
				cmd.do_fix = 1'b1;
				state_d    = stat.is_query ? gne_pkg::ST_Q_UP : gne_pkg::ST_W_RD;
			end
			gne_pkg::ST_Q_UP: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = gne_pkg::ROW_UP;
				state_d    = gne_pkg::ST_Q_MID;
			end
			gne_pkg::ST_Q_MID: begin
				// read the node's row, capture the row above
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = gne_pkg::ROW_MID;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = gne_pkg::ROW_UP;
				state_d     = gne_pkg::ST_Q_DN;
			end
			gne_pkg::ST_Q_DN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = gne_pkg::ROW_DN;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = gne_pkg::ROW_MID;
				state_d     = gne_pkg::ST_Q_CAP;
			end
			gne_pkg::ST_Q_CAP: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = gne_pkg::ROW_DN;
				slot_d      = '0;
				state_d     = gne_pkg::ST_EMIT;
			end
			gne_pkg::ST_EMIT: begin
				cmd.emit_en = 1'b1;
				slot_d      = slot_q + gne_pkg::SLOT_W'(1);
				if (slot_q == gne_pkg::SLOT_LAST) begin
					state_d = gne_pkg::ST_IDLE;
				end
			end
			gne_pkg::ST_W_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = gne_pkg::ROW_MID;
				state_d    = gne_pkg::ST_W_WB;
			end
			gne_pkg::ST_W_WB: begin
				// write back the row with the one cell updated
				cmd.wr_en = 1'b1;
				state_d   = gne_pkg::ST_IDLE;
			end
			default: begin
				state_d = gne_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/grid_neighbor_expander.sv -----
`timescale 1ns / 1ps
// Query: after start is taken the node is split into row and column and three map rows are read,
// then eight results follow at one result per cycle; a new item is taken only once the block is idle again.
// The item rate is set by the three row reads of the single map read port and the 8 results.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset: all cells free, costs 10 and 14, controller idle; no clearing pass is needed.
// Depends on gne_pkg, gne_ctrl, gne_datapath and gne_map.
module grid_neighbor_expander #(
	parameter int GRID_SIDE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [gne_pkg::NODE_W-1:0]   node,
	input  logic                         blocked,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [gne_pkg::COST_W-1:0]   cfg_data,
	output logic                         result_strobe,
	output logic [gne_pkg::SLOT_W-1:0]   direction,
	output logic [gne_pkg::NODE_W-1:0]   neighbor_node,
	output logic [gne_pkg::COST_W-1:0]   step_cost,
	output logic                         reachable,
	output logic                         last_of_run
);

	gne_pkg::gne_cmd_t  cmd;
	gne_pkg::gne_stat_t stat;

	gne_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	gne_datapath #(
		.GRID_SIDE (GRID_SIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.node          (node),
		.blocked       (blocked),
		.result_strobe (result_strobe),
		.direction     (direction),
		.neighbor_node (neighbor_node),
		.step_cost     (step_cost),
		.reachable     (reachable),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- tb/gne_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for grid_neighbor_expander: mirrors the blocked map and cost registers,
// predicts the eight neighbor results of every query and compares them in order.
// Depends on gne_pkg; instantiated by testbench next to the block.
module gne_checker #(
	parameter int GRID_SIDE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         mode,
	input  logic [gne_pkg::NODE_W-1:0]   node,
	input  logic                         blocked,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [gne_pkg::COST_W-1:0]   cfg_data,
	input  logic                         result_strobe,
	input  logic [gne_pkg::SLOT_W-1:0]   direction,
	input  logic [gne_pkg::NODE_W-1:0]   neighbor_node,
	input  logic [gne_pkg::COST_W-1:0]   step_cost,
	input  logic                         reachable,
	input  logic                         last_of_run,
	output int                           fail_count,
	output int                           pending
);
	import gne_pkg::*;

	localparam int MAP_DEPTH = 1 << NODE_W;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [SLOT_W-1:0] dir;
		logic [NODE_W-1:0] nbr;
		logic [COST_W-1:0] cost;
		logic              reach;
		logic              last;
	} neighbor_t;

	bit                wall [MAP_DEPTH];
	logic [COST_W-1:0] straight_w;
	logic [COST_W-1:0] diagonal_w;
	neighbor_t         neighbors_q[$];
	int                fails;

	function automatic bit is_free(input int r, input int c);
		return !wall[(r * GRID_SIDE + c) & (MAP_DEPTH - 1)];
	endfunction

	// queue the eight results of a query on center, in slot order
	task automatic expand_node(input logic [NODE_W-1:0] center);
		int        row, col, pos, nr, nc;
		bit        on_grid, diag, open;
		neighbor_t nb;
		row = int'(center) / GRID_SIDE;
		col = int'(center) % GRID_SIDE;
		for (int k = 0; k < 8; k++) begin
			pos = (k < 4) ? k : k + 1;
			nr = row + pos / 3 - 1;
			nc = col + pos % 3 - 1;
			diag = (nr != row) && (nc != col);
			on_grid = (int'(center) < GRID_SIDE * GRID_SIDE) && nr >= 0 && nr < GRID_SIDE
				&& nc >= 0 && nc < GRID_SIDE;
			// diagonal steps may not cut past a blocked corner cell
			open = on_grid && is_free(nr, nc) && (!diag || (is_free(row, nc) && is_free(nr, col)));
			nb.dir = SLOT_W'(k);
			nb.nbr = on_grid ? NODE_W'(nr * GRID_SIDE + nc) : '0;
			nb.cost = !open ? '0 : (diag ? diagonal_w : straight_w);
			nb.reach = open;
			nb.last = (k == 7);
			neighbors_q.push_back(nb);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		neighbor_t want;
		neighbor_t got;
		if (!arst_n) begin
			foreach (wall[i]) wall[i] = 1'b0;
			straight_w = STRAIGHT_RST;
			diagonal_w = DIAGONAL_RST;
			neighbors_q.delete();
			fails = 0;
		end else begin
			if (result_strobe) begin
				got = '{dir: direction, nbr: neighbor_node, cost: step_cost,
					reach: reachable, last: last_of_run};
				if (neighbors_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("%0t: unexpected result dir=%0d nbr=%0d cost=%0d reach=%0b last=%0b",
							$realtime, got.dir, got.nbr, got.cost, got.reach, got.last);
				end else begin
					want = neighbors_q.pop_front();
					if (got.dir !== want.dir || got.nbr !== want.nbr || got.cost !== want.cost
						|| got.reach !== want.reach || got.last !== want.last) begin
						fails++;
						if (fails <= REPORT_MAX)
							$display("%0t: mismatch exp dir=%0d nbr=%0d cost=%0d reach=%0b last=%0b, got dir=%0d nbr=%0d cost=%0d reach=%0b last=%0b",
								$realtime, want.dir, want.nbr, want.cost, want.reach, want.last,
								got.dir, got.nbr, got.cost, got.reach, got.last);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STRAIGHT: straight_w = cfg_data;
					CFG_DIAGONAL: diagonal_w = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (mode == MODE_QUERY)
					expand_node(node);
				else if (int'(node) < GRID_SIDE * GRID_SIDE)
					wall[node] = blocked;
			end
		end
		fail_count <= fails;
		pending <= neighbors_q.size();
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the grid_neighbor_expander bench: clock, reset, cell writes, queries and
// cost register writes; gne_checker does the prediction. Depends on gne_pkg.
module testbench;
	import gne_pkg::*;

	localparam int GRID_SIDE = 64;
	localparam int LAST_ROW = GRID_SIDE - 1;
	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              mode = MODE_WRITE;
	logic [NODE_W-1:0] node = '0;
	logic              blocked = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_STRAIGHT;
	logic [COST_W-1:0] cfg_data = '0;
	logic              result_strobe;
	logic [SLOT_W-1:0] direction;
	logic [NODE_W-1:0] neighbor_node;
	logic [COST_W-1:0] step_cost;
	logic              reachable;
	logic              last_of_run;
	int                fail_count;
	int                pending;
	int                cycles = 0;
	bit                gaps_on = 1'b1;

	always #5 clk = ~clk;

	grid_neighbor_expander #(.GRID_SIDE(GRID_SIDE)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .node(node), .blocked(blocked),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .direction(direction), .neighbor_node(neighbor_node),
		.step_cost(step_cost), .reachable(reachable), .last_of_run(last_of_run)
	);

	gne_checker #(.GRID_SIDE(GRID_SIDE)) i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .node(node), .blocked(blocked),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .direction(direction), .neighbor_node(neighbor_node),
		.step_cost(step_cost), .reachable(reachable), .last_of_run(last_of_run),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [NODE_W-1:0] cell_at(input int r, input int c);
		return NODE_W'(r * GRID_SIDE + c);
	endfunction

	// random cell, pulled to the border a fair share of the time
	function automatic logic [NODE_W-1:0] pick_center();
		int r, c;
		r = $urandom_range(0, LAST_ROW);
		c = $urandom_range(0, LAST_ROW);
		if ($urandom_range(0, 3) == 0)
			r = $urandom_range(0, 1) ? 0 : LAST_ROW;
		if ($urandom_range(0, 3) == 0)
			c = $urandom_range(0, 1) ? 0 : LAST_ROW;
		return cell_at(r, c);
	endfunction

	function automatic logic [NODE_W-1:0] near_cell(input logic [NODE_W-1:0] center);
		int r, c;
		r = int'(center) / GRID_SIDE + int'($urandom_range(0, 2)) - 1;
		c = int'(center) % GRID_SIDE + int'($urandom_range(0, 2)) - 1;
		if (r < 0 || r >= GRID_SIDE || c < 0 || c >= GRID_SIDE)
			return center;
		return cell_at(r, c);
	endfunction

	task automatic send_item(input logic m, input logic [NODE_W-1:0] n, input logic b);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		node <= n;
		blocked <= b;
		do @(posedge clk); while (busy);
		// drop start for a random burst now and then
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// hold off until every result has come and the block is quiet
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [COST_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly wall writes around a cell followed by a query on it, plus stray items
	task automatic random_phase(input int n_items);
		int                sent, walls, kind;
		logic [NODE_W-1:0] center;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				center = pick_center();
				walls = $urandom_range(0, 4);
				repeat (walls)
					send_item(MODE_WRITE, near_cell(center), 1'($urandom_range(0, 1)));
				send_item(MODE_QUERY, center, 1'($urandom_range(0, 1)));
				sent += walls + 1;
			end else if (kind < 8) begin
				send_item(MODE_WRITE, NODE_W'($urandom), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				send_item(MODE_QUERY, NODE_W'($urandom), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners and middle on an empty map
		send_item(MODE_QUERY, cell_at(0, 0), 1'b0);
		send_item(MODE_QUERY, cell_at(0, LAST_ROW), 1'b1);
		send_item(MODE_QUERY, cell_at(LAST_ROW, 0), 1'b0);
		send_item(MODE_QUERY, cell_at(LAST_ROW, LAST_ROW), 1'b0);
		send_item(MODE_QUERY, cell_at(32, 32), 1'b0);
		// walls upper-left and right of the center, and on the center itself
		send_item(MODE_WRITE, cell_at(31, 31), 1'b1);
		send_item(MODE_WRITE, cell_at(32, 33), 1'b1);
		send_item(MODE_WRITE, cell_at(32, 32), 1'b1);
		send_item(MODE_QUERY, cell_at(32, 32), 1'b0);
		send_item(MODE_WRITE, cell_at(32, 33), 1'b0);
		send_item(MODE_QUERY, cell_at(32, 32), 1'b1);
		// a wall straight up cuts both upper diagonals
		send_item(MODE_WRITE, cell_at(9, 10), 1'b1);
		send_item(MODE_QUERY, cell_at(10, 10), 1'b0);
		send_item(MODE_WRITE, {NODE_W{1'b1}}, 1'b1);
		send_item(MODE_QUERY, cell_at(62, 62), 1'b0);
		send_item(MODE_WRITE, {NODE_W{1'b0}}, 1'b1);
		send_item(MODE_QUERY, cell_at(1, 1), 1'b0);
		send_item(MODE_QUERY, cell_at(0, 1), 1'b1);
		send_item(MODE_WRITE, {NODE_W{1'b0}}, 1'b0);
		send_item(MODE_QUERY, 12'hAAA, 1'b1);
		send_item(MODE_QUERY, 12'h555, 1'b0);

		wait_idle();
		write_reg(CFG_STRAIGHT, 16'd1);
		write_reg(CFG_DIAGONAL, 16'hFFFF);
		random_phase(30);

		wait_idle();
		write_reg(CFG_STRAIGHT, 16'hFFFF);
		write_reg(CFG_DIAGONAL, 16'd1);
		random_phase(30);

		wait_idle();
		write_reg(CFG_STRAIGHT, 16'd0);
		write_reg(CFG_DIAGONAL, 16'd0);
		random_phase(20);

		wait_idle();
		write_reg(CFG_STRAIGHT, COST_W'($urandom_range(1, 65535)));
		write_reg(CFG_DIAGONAL, COST_W'($urandom_range(1, 65535)));
		gaps_on = 1'b0;
		random_phase(45);

		wait_idle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/gne_pkg.sv
src/gne_map.sv
src/gne_datapath.sv
src/gne_ctrl.sv
src/grid_neighbor_expander.sv
tb/gne_checker.sv
tb/testbench.sv
